// ----- hw/rtl/dnc_pkg.sv -----
// Shared types, constants and helpers for the DNS name compression writer.
// No dependencies; the other files in hw/rtl, apart from dnc_ram, refer to this package by scoped names.
package dnc_pkg;

  // Defaults for the top-level parameters.
  localparam int BUF_DEPTH_DEF   = 4096;
  localparam int MAX_OFFSETS_DEF = 512;
  localparam int MAX_HOPS_DEF    = 64;
  localparam int NAME_MAX_DEF    = 256;

  // Width of the domain that buffer offsets, pointer targets and lengths are compared in.
  localparam int ATW = 16;

  localparam logic [12:0] CAP_RESET = 13'd4096;
  localparam logic [7:0]  LABEL_MAX = 8'd63;
  localparam logic [1:0]  PTR_TAG   = 2'b11;
  localparam logic        REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_NAME  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MALF = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_OUTER_RD,
    S_OUTER_CHK,
    S_OFF_RD,
    S_M_START,
    S_M_RD,
    S_M_CHK,
    S_M_PTR,
    S_M_CMP_RD,
    S_M_CMP_CHK,
    S_FIT,
    S_COPY_RD,
    S_COPY_WR,
    S_PTR_HI,
    S_PTR_LO,
    S_DONE
  } state_t;

  // Result of comparing one buffer byte against one staged byte.
  typedef struct packed {
    logic is_ptr;
    logic over63;
    logic is_zero;
    logic eq_raw;
    logic eq_fold;
  } lbl_chk_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/dns_name_compression_writer.sv -----
// Top level of the DNS message writer with name compression.
// Depends on dnc_pkg, dnc_ram and dnc_label_check.

// One transaction at a time. Raw bytes, clears and name bytes that do not end a name go
// through the execute and done states, where the result is registered once the output is
// free, and the next transaction is taken back in idle; a read also passes a read wait
// state. The zero byte that ends a name starts a search run by one byte-compare unit under
// the sequencer: each label start of the name is read and checked, each recorded offset
// tried is fetched, and each buffer byte visited is issued and checked on the single read
// port of the message buffer, plus a pointer step per hop. Writing the name then reads and
// writes each copied byte and writes the two pointer bytes. The block is not ready while it
// works.
module dns_name_compression_writer #(
  parameter int BUF_DEPTH   = dnc_pkg::BUF_DEPTH_DEF,
  parameter int MAX_OFFSETS = dnc_pkg::MAX_OFFSETS_DEF,
  parameter int MAX_HOPS    = dnc_pkg::MAX_HOPS_DEF,
  parameter int NAME_MAX    = dnc_pkg::NAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [11:0] read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [12:0] write_position,
  output logic        name_done,
  output logic [1:0]  status,
  output logic        pointer_used,
  output logic [11:0] pointer_target,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int WPW = $clog2(BUF_DEPTH + 1);
  localparam int OFW = $clog2(MAX_OFFSETS);
  localparam int OCW = $clog2(MAX_OFFSETS + 1);
  localparam int NW  = $clog2(NAME_MAX);
  localparam int NLW = $clog2(NAME_MAX + 1);
  localparam int OW  = NW + 2;
  localparam int HW  = $clog2(MAX_HOPS + 1);
  localparam int ATW = dnc_pkg::ATW;

  dnc_pkg::state_t state, state_next;

  // Architectural state.
  logic [WPW-1:0] wp;
  logic [OCW-1:0] oc;
  logic [NLW-1:0] nl;
  logic [6:0]     lr;
  logic           name_error;
  logic [12:0]    capacity;

  // Latched transaction.
  dnc_pkg::cmd_t cmd_r;
  logic [7:0]    byte_r;
  logic [11:0]   addr_r;

  // Search and copy registers.
  logic [OW-1:0]  wlen, o, w, copy_i, copy_n, next_lab;
  logic [5:0]     lab, llen, cnt, ptr_hi;
  logic [OCW-1:0] k;
  logic [ATW-1:0] at;
  logic [HW-1:0]  hops;
  logic [AW-1:0]  t;
  logic           found;

  // Result being built.
  logic [7:0]        res_rd;
  logic              res_done;
  dnc_pkg::status_t  res_status;
  logic              res_used;
  logic [11:0]       res_target;

  // Memory ports.
  logic           buf_we;
  logic [AW-1:0]  buf_waddr, buf_raddr;
  logic [7:0]     buf_wdata, buf_q;
  logic           stg_we;
  logic [NW-1:0]  stg_waddr, stg_raddr;
  logic [7:0]     stg_wdata, stg_q;
  logic           off_we;
  logic [OFW-1:0] off_waddr, off_raddr;
  logic [AW-1:0]  off_wdata, off_q;

  dnc_pkg::lbl_chk_t chk;

  dnc_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_q)
  );

  dnc_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_stg (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
    .raddr(stg_raddr), .rdata(stg_q)
  );

  dnc_ram #(.WIDTH(AW), .DEPTH(MAX_OFFSETS)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_q)
  );

  dnc_label_check u_chk (
    .buf_byte(buf_q),
    .stg_byte(stg_q),
    .chk(chk)
  );

  // Derived conditions.
  logic [ATW-1:0] len, cap16, at1, atc, t16, cpos, ppos;
  logic [OW-1:0]  wc;
  logic raw_full, rd_in_range, nl_over, nm_store, nm_final;
  logic k_end, ptr_bad, lbl_fail, over_len, cmp_end, fits, rec, m_fail, cfg_wr;
  logic exec_done;
  dnc_pkg::status_t exec_status;

  assign len   = ATW'(wp);
  assign cap16 = (ATW'(capacity) > ATW'(BUF_DEPTH)) ? ATW'(BUF_DEPTH) : ATW'(capacity);
  assign at1   = at + ATW'(1);
  assign atc   = at + ATW'(cnt);
  assign wc    = w + OW'(cnt);
  assign t16   = ATW'(t);
  assign cpos  = len + ATW'(copy_i);
  assign ppos  = len + ATW'(o);

  assign raw_full    = (len >= cap16);
  assign rd_in_range = (32'(addr_r) < 32'(BUF_DEPTH));
  assign nl_over     = (32'(nl) >= 32'(NAME_MAX - 1));
  assign nm_store    = !name_error && !nl_over && ((lr != 7'd0) || (byte_r <= dnc_pkg::LABEL_MAX));
  assign nm_final    = !name_error && !nl_over && (lr == 7'd0) && (byte_r == 8'd0);

  // Status and name completion of a transaction as decided in the execute state.
  assign exec_status = (cmd_r == dnc_pkg::CMD_RAW && raw_full) ? dnc_pkg::ST_FULL :
                       (cmd_r == dnc_pkg::CMD_NAME && (name_error || nl_over ||
                        (lr == 7'd0 && byte_r > dnc_pkg::LABEL_MAX))) ? dnc_pkg::ST_MALF :
                       dnc_pkg::ST_OK;
  assign exec_done   = (cmd_r == dnc_pkg::CMD_NAME) && (byte_r == 8'd0) &&
                       (name_error || nl_over || (lr == 7'd0));

  assign k_end    = (k >= oc);
  assign ptr_bad  = (at1 >= len) || (hops == HW'(MAX_HOPS));
  assign lbl_fail = (w >= wlen) || chk.over63 || !chk.eq_raw;
  assign over_len = (at1 + ATW'(buf_q)) > len;
  assign cmp_end  = (wc >= wlen);
  assign fits     = found ? ((ppos + ATW'(2)) <= cap16) : ((len + ATW'(wlen)) <= cap16);
  assign rec      = (copy_i == next_lab) && (stg_q != 8'd0) &&
                    (stg_q[7:6] != dnc_pkg::PTR_TAG) && (oc < OCW'(MAX_OFFSETS));

  assign in_ready = (state == dnc_pkg::S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == dnc_pkg::REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dnc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    m_fail     = 1'b0;
    buf_we     = 1'b0;
    buf_waddr  = '0;
    buf_wdata  = '0;
    buf_raddr  = '0;
    stg_we     = 1'b0;
    stg_waddr  = '0;
    stg_wdata  = '0;
    stg_raddr  = '0;
    off_we     = 1'b0;
    off_waddr  = '0;
    off_wdata  = '0;
    off_raddr  = '0;
    unique case (state)
      dnc_pkg::S_IDLE: begin
        if (in_valid) state_next = dnc_pkg::S_EXEC;
      end
      dnc_pkg::S_EXEC: begin
        unique case (cmd_r)
          dnc_pkg::CMD_RAW: begin
            if (!raw_full) begin
              buf_we    = 1'b1;
              buf_waddr = len[AW-1:0];
              buf_wdata = byte_r;
            end
            state_next = dnc_pkg::S_DONE;
          end
          dnc_pkg::CMD_READ: begin
            buf_raddr  = AW'(addr_r);
            state_next = rd_in_range ? dnc_pkg::S_RDWAIT : dnc_pkg::S_DONE;
          end
          dnc_pkg::CMD_CLEAR: state_next = dnc_pkg::S_DONE;
          dnc_pkg::CMD_NAME: begin
            if (nm_store) begin
              stg_we    = 1'b1;
              stg_waddr = nl[NW-1:0];
              stg_wdata = byte_r;
            end
            state_next = nm_final ? dnc_pkg::S_OUTER_RD : dnc_pkg::S_DONE;
          end
          default: state_next = dnc_pkg::S_DONE;
        endcase
      end
      dnc_pkg::S_RDWAIT: state_next = dnc_pkg::S_DONE;
      dnc_pkg::S_OUTER_RD: begin
        if (o >= wlen) begin
          state_next = dnc_pkg::S_FIT;
        end else begin
          stg_raddr  = o[NW-1:0];
          state_next = dnc_pkg::S_OUTER_CHK;
        end
      end
      dnc_pkg::S_OUTER_CHK: begin
        state_next = (stg_q == 8'd0) ? dnc_pkg::S_FIT : dnc_pkg::S_OFF_RD;
      end
      dnc_pkg::S_OFF_RD: begin
        if (k_end) begin
          state_next = dnc_pkg::S_OUTER_RD;
        end else begin
          off_raddr  = k[OFW-1:0];
          state_next = dnc_pkg::S_M_START;
        end
      end
      dnc_pkg::S_M_START: state_next = dnc_pkg::S_M_RD;
      dnc_pkg::S_M_RD: begin
        if (at >= len) begin
          m_fail     = 1'b1;
          state_next = dnc_pkg::S_OFF_RD;
        end else begin
          buf_raddr  = at[AW-1:0];
          stg_raddr  = w[NW-1:0];
          state_next = dnc_pkg::S_M_CHK;
        end
      end
      dnc_pkg::S_M_CHK: begin
        priority if (chk.is_ptr) begin
          if (ptr_bad) begin
            m_fail     = 1'b1;
            state_next = dnc_pkg::S_OFF_RD;
          end else begin
            buf_raddr  = at1[AW-1:0];
            state_next = dnc_pkg::S_M_PTR;
          end
        end else if (lbl_fail) begin
          m_fail     = 1'b1;
          state_next = dnc_pkg::S_OFF_RD;
        end else if (chk.is_zero) begin
          state_next = dnc_pkg::S_FIT;
        end else if (over_len) begin
          m_fail     = 1'b1;
          state_next = dnc_pkg::S_OFF_RD;
        end else begin
          state_next = dnc_pkg::S_M_CMP_RD;
        end
      end
      dnc_pkg::S_M_PTR: state_next = dnc_pkg::S_M_RD;
      dnc_pkg::S_M_CMP_RD: begin
        if (cmp_end) begin
          m_fail     = 1'b1;
          state_next = dnc_pkg::S_OFF_RD;
        end else begin
          buf_raddr  = atc[AW-1:0];
          stg_raddr  = wc[NW-1:0];
          state_next = dnc_pkg::S_M_CMP_CHK;
        end
      end
      dnc_pkg::S_M_CMP_CHK: begin
        priority if (!chk.eq_fold) begin
          m_fail     = 1'b1;
          state_next = dnc_pkg::S_OFF_RD;
        end else if (cnt == llen) begin
          state_next = dnc_pkg::S_M_RD;
        end else begin
          state_next = dnc_pkg::S_M_CMP_RD;
        end
      end
      dnc_pkg::S_FIT: state_next = fits ? dnc_pkg::S_COPY_RD : dnc_pkg::S_DONE;
      dnc_pkg::S_COPY_RD: begin
        if (copy_i >= copy_n) begin
          state_next = found ? dnc_pkg::S_PTR_HI : dnc_pkg::S_DONE;
        end else begin
          stg_raddr  = copy_i[NW-1:0];
          state_next = dnc_pkg::S_COPY_WR;
        end
      end
      dnc_pkg::S_COPY_WR: begin
        buf_we    = 1'b1;
        buf_waddr = cpos[AW-1:0];
        buf_wdata = stg_q;
        if (rec) begin
          off_we    = 1'b1;
          off_waddr = oc[OFW-1:0];
          off_wdata = cpos[AW-1:0];
        end
        state_next = dnc_pkg::S_COPY_RD;
      end
      dnc_pkg::S_PTR_HI: begin
        buf_we     = 1'b1;
        buf_waddr  = ppos[AW-1:0];
        buf_wdata  = {dnc_pkg::PTR_TAG, t16[13:8]};
        state_next = dnc_pkg::S_PTR_LO;
      end
      dnc_pkg::S_PTR_LO: begin
        buf_we     = 1'b1;
        buf_waddr  = AW'(ppos + ATW'(1));
        buf_wdata  = t16[7:0];
        state_next = dnc_pkg::S_DONE;
      end
      dnc_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = dnc_pkg::S_IDLE;
      end
      default: state_next = dnc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      oc         <= '0;
      nl         <= '0;
      lr         <= '0;
      name_error <= 1'b0;
      capacity   <= dnc_pkg::CAP_RESET;
      out_valid  <= 1'b0;
      hops       <= '0;
    end else begin
      if (cfg_wr && paddr[2] == dnc_pkg::REG_CAPACITY) begin
        capacity <= pwdata[12:0];
      end
      if (state == dnc_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (m_fail) begin
        k <= k + OCW'(1);
      end
      unique case (state)
        dnc_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= dnc_pkg::cmd_t'(command);
            byte_r <= data_byte;
            addr_r <= read_address;
          end
        end
        dnc_pkg::S_EXEC: begin
          res_rd     <= 8'd0;
          res_done   <= exec_done;
          res_status <= exec_status;
          res_used   <= 1'b0;
          res_target <= 12'd0;
          found      <= 1'b0;
          o          <= '0;
          unique case (cmd_r)
            dnc_pkg::CMD_RAW: begin
              if (!raw_full) wp <= wp + WPW'(1);
            end
            dnc_pkg::CMD_CLEAR: begin
              wp         <= '0;
              oc         <= '0;
              nl         <= '0;
              lr         <= '0;
              name_error <= 1'b0;
            end
            dnc_pkg::CMD_NAME: begin
              priority if (name_error || nl_over) begin
                // A bad name ends at the next zero byte wherever it falls.
                name_error <= (byte_r != 8'd0);
                if (byte_r == 8'd0) begin
                  nl <= '0;
                  lr <= '0;
                end
              end else if (lr != 7'd0) begin
                nl <= nl + NLW'(1);
                lr <= lr - 7'd1;
              end else if (byte_r > dnc_pkg::LABEL_MAX) begin
                name_error <= 1'b1;
              end else if (byte_r == 8'd0) begin
                wlen <= OW'(nl) + OW'(1);
                nl   <= '0;
                lr   <= '0;
              end else begin
                nl <= nl + NLW'(1);
                lr <= byte_r[6:0];
              end
            end
            default: ;
          endcase
        end
        dnc_pkg::S_RDWAIT: res_rd <= buf_q;
        dnc_pkg::S_OUTER_CHK: begin
          lab <= stg_q[5:0];
          k   <= '0;
        end
        dnc_pkg::S_OFF_RD: begin
          if (k_end) o <= o + OW'(1) + OW'(lab);
        end
        dnc_pkg::S_M_START: begin
          t    <= off_q;
          at   <= ATW'(off_q);
          w    <= o;
          hops <= '0;
        end
        dnc_pkg::S_M_CHK: begin
          if (state_next == dnc_pkg::S_M_PTR) begin
            hops   <= hops + HW'(1);
            ptr_hi <= buf_q[5:0];
          end else if (state_next == dnc_pkg::S_FIT) begin
            found <= 1'b1;
          end else if (state_next == dnc_pkg::S_M_CMP_RD) begin
            llen <= buf_q[5:0];
            cnt  <= 6'd1;
          end
        end
        dnc_pkg::S_M_PTR: at <= ATW'({ptr_hi, buf_q});
        dnc_pkg::S_M_CMP_CHK: begin
          if (chk.eq_fold) begin
            if (cnt == llen) begin
              at <= at1 + ATW'(llen);
              w  <= w + OW'(1) + OW'(llen);
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end
        dnc_pkg::S_FIT: begin
          if (!fits) res_status <= dnc_pkg::ST_FULL;
          copy_n   <= found ? o : wlen;
          copy_i   <= '0;
          next_lab <= '0;
        end
        dnc_pkg::S_COPY_RD: begin
          if (copy_i >= copy_n && !found) wp <= wp + WPW'(copy_n);
        end
        dnc_pkg::S_COPY_WR: begin
          copy_i <= copy_i + OW'(1);
          if (copy_i == next_lab) next_lab <= copy_i + OW'(1) + OW'(stg_q);
          if (rec) oc <= oc + OCW'(1);
        end
        dnc_pkg::S_PTR_LO: begin
          wp         <= WPW'(ppos + ATW'(2));
          res_used   <= 1'b1;
          res_target <= t16[11:0];
        end
        dnc_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            read_data      <= res_rd;
            write_position <= 13'(wp);
            name_done      <= res_done;
            status         <= res_status;
            pointer_used   <= res_used;
            pointer_target <= res_target;
          end
        end
        default: ;
      endcase
    end
  end

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wp) <= 32'(BUF_DEPTH))
    else $error("write position beyond buffer depth");

  a_oc_bound: assert property (@(posedge clk) disable iff (rst)
    32'(oc) <= 32'(MAX_OFFSETS))
    else $error("offset count beyond table size");

  a_hops_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hops) <= 32'(MAX_HOPS) || state == dnc_pkg::S_IDLE)
    else $error("pointer hops beyond limit");

  a_copy_fits: assert property (@(posedge clk) disable iff (rst)
    state == dnc_pkg::S_COPY_WR |-> cpos < cap16)
    else $error("name copy beyond capacity");

endmodule

// ----- hw/rtl/dnc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dnc_label_check.sv -----
// Byte compare unit shared by the label checks and byte compares of the suffix search.
// Depends on dnc_pkg for the result struct and the case fold.
module dnc_label_check (
  input  logic [7:0]          buf_byte,
  input  logic [7:0]          stg_byte,
  output dnc_pkg::lbl_chk_t   chk
);

  always_comb begin
    chk.is_ptr  = (buf_byte[7:6] == dnc_pkg::PTR_TAG);
    chk.over63  = (buf_byte > dnc_pkg::LABEL_MAX);
    chk.is_zero = (buf_byte == 8'd0);
    chk.eq_raw  = (buf_byte == stg_byte);
    chk.eq_fold = (dnc_pkg::fold(buf_byte) == dnc_pkg::fold(stg_byte));
  end

endmodule

// ----- dv/dns_name_compression_writer_check.sv -----
// Checker for the DNS name compression writer: watches both channels and the APB port,
// predicts every result from its own copy of the writer state, and compares.
// Depends on dnc_pkg for the command and status codes.
module dns_name_compression_writer_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [11:0] read_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_data,
  input  logic [12:0] write_position,
  input  logic        name_done,
  input  logic [1:0]  status,
  input  logic        pointer_used,
  input  logic [11:0] pointer_target,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding,
  output int          high_water
);

  localparam int DEPTH = dnc_pkg::BUF_DEPTH_DEF;
  localparam int OFFS  = dnc_pkg::MAX_OFFSETS_DEF;
  localparam int HOPS  = dnc_pkg::MAX_HOPS_DEF;
  localparam int NMAX  = dnc_pkg::NAME_MAX_DEF;
  localparam logic [2:0] CAP_ADDR = {dnc_pkg::REG_CAPACITY, 2'b00};

  typedef struct {
    logic [7:0]  rd;
    logic [12:0] wp;
    logic        done;
    logic [1:0]  st;
    logic        used;
    logic [11:0] tgt;
  } writer_result_t;

  logic [7:0]  msg_mem [DEPTH];
  logic [11:0] label_starts [OFFS];
  logic [7:0]  staged [NMAX];
  int wpos, start_count, staged_len, label_left, capacity_reg;
  bit bad_name;
  writer_result_t pending_results [$];

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic void note_label_starts(input int at);
    logic [7:0] l;
    while (at < wpos && at < 'h4000 && start_count < OFFS) begin
      l = msg_mem[at];
      if (l == 0 || l[7:6] != 2'b00) return;
      label_starts[start_count] = at[11:0];
      start_count++;
      at += 1 + l;
    end
  endfunction

  // Compares the stored name at 'at' (bounded by 'len') with the staged name from 'w'.
  function automatic bit suffix_hit(input int len, input int at, input int w, input int wlen);
    int hops;
    int k;
    logic [7:0] l;
    hops = 0;
    while (at < len) begin
      l = msg_mem[at];
      if (l[7:6] == 2'b11) begin
        if (at + 1 >= len) return 0;
        hops++;
        if (hops > HOPS) return 0;
        at = {l[5:0], msg_mem[at + 1]};
        continue;
      end
      if (w >= wlen || l > 63 || l != staged[w]) return 0;
      if (l == 0) return 1;
      if (at + 1 + l > len) return 0;
      for (k = 1; k <= l; k++) begin
        if (w + k >= wlen) return 0;
        if (lower_ascii(msg_mem[at + k]) != lower_ascii(staged[w + k])) return 0;
      end
      at += 1 + l;
      w += 1 + l;
    end
    return 0;
  endfunction

  function automatic logic [1:0] place_name(input int wlen, input int cap,
                                            output logic used, output logic [11:0] tgt);
    int start, o, k, t, j;
    start = wpos;
    used = 0;
    tgt = 0;
    for (o = 0; o < wlen && staged[o] != 0; o += 1 + staged[o]) begin
      for (k = 0; k < start_count; k++) begin
        t = label_starts[k];
        if (!suffix_hit(start, t, o, wlen)) continue;
        if (start + o + 2 > cap) return dnc_pkg::ST_FULL;
        for (j = 0; j < o; j++) msg_mem[start + j] = staged[j];
        msg_mem[start + o] = {2'b11, t[13:8]};
        msg_mem[start + o + 1] = t[7:0];
        wpos = start + o + 2;
        note_label_starts(start);
        used = 1;
        tgt = t[11:0];
        return dnc_pkg::ST_OK;
      end
    end
    if (start + wlen > cap) return dnc_pkg::ST_FULL;
    for (j = 0; j < wlen; j++) msg_mem[start + j] = staged[j];
    wpos = start + wlen;
    note_label_starts(start);
    return dnc_pkg::ST_OK;
  endfunction

  function automatic void drop_staged();
    staged_len = 0;
    label_left = 0;
    bad_name = 0;
  endfunction

  function automatic writer_result_t predict_item(input dnc_pkg::cmd_t c, input logic [7:0] b,
                                                  input logic [11:0] a);
    writer_result_t r;
    int cap;
    cap = capacity_reg < DEPTH ? capacity_reg : DEPTH;
    r = '{rd: 8'd0, wp: 13'd0, done: 1'b0, st: dnc_pkg::ST_OK, used: 1'b0, tgt: 12'd0};
    case (c)
      dnc_pkg::CMD_RAW: begin
        if (wpos >= cap) r.st = dnc_pkg::ST_FULL;
        else begin
          msg_mem[wpos] = b;
          wpos++;
        end
      end
      dnc_pkg::CMD_NAME: begin
        if (bad_name || staged_len >= NMAX - 1) begin
          bad_name = 1;
          r.st = dnc_pkg::ST_MALF;
          if (b == 0) begin
            r.done = 1;
            drop_staged();
          end
        end else if (label_left > 0) begin
          staged[staged_len++] = b;
          label_left--;
        end else if (b > 63) begin
          bad_name = 1;
          r.st = dnc_pkg::ST_MALF;
        end else if (b == 0) begin
          staged[staged_len++] = 0;
          r.done = 1;
          r.st = place_name(staged_len, cap, r.used, r.tgt);
          drop_staged();
        end else begin
          staged[staged_len++] = b;
          label_left = b;
        end
      end
      dnc_pkg::CMD_READ: r.rd = msg_mem[a];
      default: begin
        wpos = 0;
        start_count = 0;
        drop_staged();
      end
    endcase
    r.wp = wpos[12:0];
    return r;
  endfunction

  always @(posedge clk) begin
    writer_result_t exp_r;
    int fails;
    fails = 0;
    if (rst) begin
      wpos = 0;
      start_count = 0;
      capacity_reg = dnc_pkg::CAP_RESET;
      drop_staged();
      pending_results.delete();
      foreach (msg_mem[i]) msg_mem[i] = 0;
      errors <= 0;
      high_water <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        capacity_reg = pwdata[12:0];
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          fails++;
        end else begin
          exp_r = pending_results.pop_front();
          if (read_data !== exp_r.rd) begin
            $error("read_data expected %0d actual %0d", exp_r.rd, read_data);
            fails++;
          end
          if (write_position !== exp_r.wp) begin
            $error("write_position expected %0d actual %0d", exp_r.wp, write_position);
            fails++;
          end
          if (name_done !== exp_r.done) begin
            $error("name_done expected %0d actual %0d", exp_r.done, name_done);
            fails++;
          end
          if (status !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, status);
            fails++;
          end
          if (pointer_used !== exp_r.used) begin
            $error("pointer_used expected %0d actual %0d", exp_r.used, pointer_used);
            fails++;
          end
          if (pointer_target !== exp_r.tgt) begin
            $error("pointer_target expected %0d actual %0d", exp_r.tgt, pointer_target);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_item(dnc_pkg::cmd_t'(command), data_byte,
                                               read_address));
        if (wpos > high_water) high_water <= wpos;
      end
      errors <= errors + fails;
    end
    outstanding <= pending_results.size();
  end
endmodule

// ----- dv/dns_name_compression_writer_test.sv -----
// Top of the DNS name compression writer testbench: clock, reset, stimulus and verdict.
// Depends on dnc_pkg, the writer RTL and dns_name_compression_writer_check.
module dns_name_compression_writer_test;

  localparam logic [2:0] CAP_ADDR = {dnc_pkg::REG_CAPACITY, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = dnc_pkg::CMD_RAW;
  logic [7:0]  data_byte = 8'd0;
  logic [11:0] read_address = 12'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  read_data;
  logic [12:0] write_position;
  logic        name_done;
  logic [1:0]  status;
  logic        pointer_used;
  logic [11:0] pointer_target;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  int errors, outstanding, high_water;
  int item_count = 0;
  bit calm = 0;

  // Recent names, kept so that later names can share their suffixes.
  logic [7:0] name_bytes [256];
  int name_len;
  logic [7:0] name_pool [8][64];
  int pool_count = 0, pool_slot = 0;

  dns_name_compression_writer dut (.*);
  dns_name_compression_writer_check checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= (rst || calm) ? 1'b1 : ($urandom_range(99) >= 13);

  task automatic send(input dnc_pkg::cmd_t c, input logic [7:0] b, input logic [11:0] a);
    logic taken;
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    data_byte <= b;
    read_address <= a;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    item_count++;
    calm = item_count >= 500 && item_count < 750;
  endtask

  // Stops sending and waits until every expected result transaction has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input int v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CAP_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic raw_byte();
    send(dnc_pkg::CMD_RAW, 8'($urandom_range(255)), 12'($urandom_range(4095)));
  endtask

  task automatic read_back();
    if (high_water == 0) raw_byte();
    else send(dnc_pkg::CMD_READ, 8'($urandom_range(255)), 12'($urandom_range(high_water - 1)));
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(99) < 3) return 8'($urandom_range(255));
    c = 8'h61 + 8'($urandom_range(3));
    return $urandom_range(1) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) && $urandom_range(1))
      return c ^ 8'h20;
    return c;
  endfunction

  task automatic add_labels(input int n);
    int i, k, l;
    for (i = 0; i < n; i++) begin
      l = $urandom_range(1, 6);
      name_bytes[name_len++] = 8'(l);
      for (k = 0; k < l; k++) name_bytes[name_len++] = name_char();
    end
  endtask

  task automatic make_name();
    int p, ns, j, i, l, pick;
    int starts [32];
    name_len = 0;
    if (pool_count > 0 && $urandom_range(1)) begin
      p = $urandom_range(pool_count - 1);
      ns = 0;
      j = 0;
      while (name_pool[p][j] != 0) begin
        starts[ns++] = j;
        j += 1 + name_pool[p][j];
      end
      pick = starts[$urandom_range(ns - 1)];
      add_labels($urandom_range(0, 2));
      j = pick;
      while (name_pool[p][j] != 0) begin
        l = name_pool[p][j];
        name_bytes[name_len++] = 8'(l);
        for (i = 1; i <= l; i++) name_bytes[name_len++] = flip_case(name_pool[p][j + i]);
        j += 1 + l;
      end
    end else begin
      add_labels($urandom_range(1, 3));
    end
    name_bytes[name_len++] = 8'd0;
    if (name_len <= 40) begin
      for (i = 0; i < name_len; i++) name_pool[pool_slot][i] = name_bytes[i];
      pool_slot = (pool_slot + 1) % 8;
      if (pool_count < 8) pool_count++;
    end
  endtask

  // Sends the staged name, with the odd raw byte or read slipped in between.
  task automatic send_name();
    int i;
    for (i = 0; i < name_len; i++) begin
      if ($urandom_range(99) < 6) begin
        if ($urandom_range(1)) raw_byte();
        else read_back();
      end
      send(dnc_pkg::CMD_NAME, name_bytes[i], 12'($urandom_range(4095)));
    end
  endtask

  task automatic send_bad_name();
    int i;
    name_len = 0;
    add_labels($urandom_range(0, 2));
    // A length byte above 63, which covers the compression pointer tags.
    name_bytes[name_len++] = $urandom_range(1) ? (8'hC0 | 8'($urandom_range(63)))
                                               : 8'($urandom_range(64, 255));
    for (i = $urandom_range(0, 4); i > 0; i--) name_bytes[name_len++] = 8'($urandom_range(1, 255));
    name_bytes[name_len++] = 8'd0;
    send_name();
  endtask

  task automatic send_long_name();
    int i, k;
    for (i = 0; i < 4; i++) begin
      send(dnc_pkg::CMD_NAME, dnc_pkg::LABEL_MAX, 12'd0);
      for (k = 0; k < 63; k++) send(dnc_pkg::CMD_NAME, name_char(), 12'd0);
    end
    send(dnc_pkg::CMD_NAME, 8'h00, 12'd0);
  endtask

  task automatic send_list(input logic [7:0] seq [], input dnc_pkg::cmd_t c);
    foreach (seq[i]) send(c, seq[i], 12'd0);
  endtask

  initial begin
    int r, i;
    bit mid_done, late_done;
    mid_done = 0;
    late_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_capacity(dnc_pkg::CAP_RESET);

    send(dnc_pkg::CMD_RAW, 8'h00, 12'd0);
    send(dnc_pkg::CMD_RAW, 8'hFF, 12'hFFF);
    send(dnc_pkg::CMD_READ, 8'd0, 12'd1);
    send_list('{8'd3, 8'h41, 8'h62, 8'h63, 8'd0}, dnc_pkg::CMD_NAME);
    // Same name in other case: must compress to a pointer.
    send_list('{8'd3, 8'h61, 8'h42, 8'h43, 8'd0}, dnc_pkg::CMD_NAME);
    send_list('{8'd1, 8'h78, 8'd0}, dnc_pkg::CMD_NAME);
    send_list('{8'h40, 8'd0}, dnc_pkg::CMD_NAME);
    send_list('{8'hC0, 8'd0}, dnc_pkg::CMD_NAME);
    send(dnc_pkg::CMD_READ, 8'd0, 12'd6);
    send(dnc_pkg::CMD_CLEAR, 8'd0, 12'd0);
    send(dnc_pkg::CMD_READ, 8'd0, 12'd0);
    settle();

    set_capacity(12);
    send(dnc_pkg::CMD_CLEAR, 8'd0, 12'd0);
    for (i = 0; i < 10; i++) raw_byte();
    send_list('{8'd3, 8'h61, 8'h62, 8'h63, 8'd0}, dnc_pkg::CMD_NAME);
    for (i = 0; i < 3; i++) raw_byte();
    settle();

    set_capacity(dnc_pkg::CAP_RESET);
    send(dnc_pkg::CMD_CLEAR, 8'd0, 12'd0);
    for (i = 0; i < 300; i++) raw_byte();
    send_long_name();
    settle();
    send(dnc_pkg::CMD_READ, 8'd0, 12'(high_water - 1));
    send(dnc_pkg::CMD_READ, 8'd0, 12'd150);
    send(dnc_pkg::CMD_CLEAR, 8'd0, 12'd0);

    while (item_count < 1450) begin
      if (!mid_done && item_count >= 900) begin
        mid_done = 1;
        settle();
        set_capacity(300);
      end
      if (!late_done && item_count >= 1200) begin
        late_done = 1;
        settle();
        set_capacity(dnc_pkg::CAP_RESET);
      end
      r = $urandom_range(99);
      if (r < 45) begin
        make_name();
        send_name();
      end else if (r < 65) raw_byte();
      else if (r < 85) read_back();
      else if (r < 90) send(dnc_pkg::CMD_CLEAR, 8'($urandom_range(255)),
                            12'($urandom_range(4095)));
      else send_bad_name();
    end
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
